// ===== hw/rtl/ellr_pkg.sv =====
package ellr_pkg;

  // item kinds as classified by the front
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_ADV   = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SEMI_AXIS_X = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SEMI_AXIS_Y = 1'b1;

  localparam int SEMI_AXIS_X_RST = 70;
  localparam int SEMI_AXIS_Y_RST = 50;

  // core -> emitter control
  typedef struct packed {
    logic launch;   // snapshot the current point and start a group
    logic fin;      // step done, end flag valid
    logic fin_end;  // curve finished with this group
  } emit_ctl_t;

endpackage

// ===== hw/rtl/ellr_front.sv =====
module ellr_front #(
  parameter int COORD_BITS = 11
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  mode,
  input  logic [COORD_BITS-1:0] center_x,
  input  logic [COORD_BITS-1:0] center_y,
  output logic                  q_valid,
  output logic                  q_kind,
  output logic [COORD_BITS-1:0] q_cx,
  output logic [COORD_BITS-1:0] q_cy,
  input  logic                  q_pop
);

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  logic                  ent_kind [Q_DEPTH];
  logic [COORD_BITS-1:0] ent_cx   [Q_DEPTH];
  logic [COORD_BITS-1:0] ent_cy   [Q_DEPTH];
  logic [Q_AW-1:0]       wr_ptr;
  logic [Q_AW-1:0]       rd_ptr;
  logic [Q_AW:0]         count;
  logic                  push;
  logic                  kind;

  assign in_stall = (count == (Q_AW+1)'(Q_DEPTH));
  assign push     = in_valid && !in_stall;
  assign kind     = mode ? ellr_pkg::KIND_ADV : ellr_pkg::KIND_START;

  assign q_valid = (count != '0);
  assign q_kind  = ent_kind[rd_ptr];
  assign q_cx    = ent_cx[rd_ptr];
  assign q_cy    = ent_cy[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_kind[wr_ptr] <= kind;
      ent_cx[wr_ptr]   <= center_x;
      ent_cy[wr_ptr]   <= center_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (!push && q_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/ellr_core.sv =====
module ellr_core #(
  parameter int COORD_BITS = 11,
  parameter int AXIS_BITS  = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [AXIS_BITS-1:0]   semi_x,
  input  logic [AXIS_BITS-1:0]   semi_y,
  input  logic                   q_valid,
  input  logic                   q_kind,
  input  logic [COORD_BITS-1:0]  q_cx,
  input  logic [COORD_BITS-1:0]  q_cy,
  output logic                   q_pop,
  input  logic                   emit_busy,
  output ellr_pkg::emit_ctl_t    emit_ctl,
  output logic [AXIS_BITS-1:0]   cur_x,
  output logic [AXIS_BITS-1:0]   cur_y,
  output logic [COORD_BITS-1:0]  cen_x,
  output logic [COORD_BITS-1:0]  cen_y
);

  localparam int SW  = 3*AXIS_BITS + 4;  // slope width
  localparam int DW  = 4*AXIS_BITS + 8;  // decision width
  localparam int MAW = 2*AXIS_BITS;
  localparam int MBW = 2*AXIS_BITS + 2;
  localparam int PRW = MAW + MBW;

  localparam logic [3:0] C_IDLE = 4'd0;
  localparam logic [3:0] C_ST0  = 4'd1;
  localparam logic [3:0] C_ST1  = 4'd2;
  localparam logic [3:0] C_R1A  = 4'd3;
  localparam logic [3:0] C_R1B  = 4'd4;
  localparam logic [3:0] C_R1C  = 4'd5;
  localparam logic [3:0] C_R2A  = 4'd6;
  localparam logic [3:0] C_R2B  = 4'd7;
  localparam logic [3:0] C_SET  = 4'd8;
  localparam logic [3:0] C_E0   = 4'd9;
  localparam logic [3:0] C_E1   = 4'd10;
  localparam logic [3:0] C_E2   = 4'd11;
  localparam logic [3:0] C_E3   = 4'd12;
  localparam logic [3:0] C_E4   = 4'd13;
  localparam logic [3:0] C_E5   = 4'd14;

  logic [3:0]           state;
  logic [AXIS_BITS-1:0] step_x;
  logic [AXIS_BITS-1:0] step_y;
  logic                 in_two;
  logic                 running;
  logic                 is_adv;
  logic [DW-1:0]        dec;
  logic [SW-1:0]        dx;
  logic [SW-1:0]        dy;
  logic [MAW-1:0]       a2;
  logic [MAW-1:0]       b2;
  logic [PRW-1:0]       prod;
  logic [MBW-1:0]       tmp;
  logic [DW-1:0]        acc;

  logic [MAW-1:0]       ma;
  logic [MBW-1:0]       mb;
  logic [AXIS_BITS-1:0] x_inc;
  logic [AXIS_BITS-1:0] y_dec;
  logic [AXIS_BITS-1:0] ym1;
  logic [AXIS_BITS:0]   t_odd;
  logic [SW-1:0]        prod_x2;
  logic [SW-1:0]        dy_alt;
  logic [SW-1:0]        dx_alt;
  logic [DW-1:0]        a2e;
  logic [DW-1:0]        b2e;
  logic                 p_neg;
  logic                 p_pos;
  logic                 set_enter;
  logic                 pop_ok;

  function automatic logic [DW-1:0] sext(input logic [SW-1:0] v);
    return {{(DW-SW){v[SW-1]}}, v};
  endfunction

  function automatic logic [DW-1:0] x4(input logic [DW-1:0] v);
    return {v[DW-3:0], 2'b00};
  endfunction

  assign x_inc   = step_x + 1'b1;
  assign y_dec   = (step_y != '0) ? step_y - 1'b1 : '0;
  // (y-1)^2 with y = 0 squares minus one
  assign ym1     = (step_y != '0) ? step_y - 1'b1 : AXIS_BITS'(1);
  assign t_odd   = {step_x, 1'b1};
  assign prod_x2 = SW'({prod, 1'b0});
  assign dy_alt  = dy - SW'({a2, 1'b0});
  assign dx_alt  = dx + SW'({b2, 1'b0});
  assign a2e     = DW'(a2);
  assign b2e     = DW'(b2);
  assign p_neg   = dec[DW-1];
  assign p_pos   = !dec[DW-1] && (dec != '0);
  assign set_enter = !in_two && !($signed(dx) < $signed(dy));

  assign pop_ok  = (state == C_IDLE) && q_valid && !emit_busy;
  assign q_pop   = pop_ok;

  assign emit_ctl.launch  = pop_ok && (q_kind == ellr_pkg::KIND_ADV) && running;
  assign emit_ctl.fin     = is_adv && (((state == C_SET) && !set_enter) || (state == C_E5));
  assign emit_ctl.fin_end = (step_y == '0) && (in_two || (state == C_E5));

  assign cur_x = step_x;
  assign cur_y = step_y;

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      C_ST0: begin
        ma = a2;
        mb = MBW'(semi_y);
      end
      C_R1A: begin
        ma = b2;
        mb = MBW'(x_inc);
      end
      C_R1B, C_R2A: begin
        ma = a2;
        mb = MBW'(y_dec);
      end
      C_E0: begin
        ma = MAW'(t_odd);
        mb = MBW'(t_odd);
      end
      C_E1: begin
        ma = MAW'(ym1);
        mb = MBW'(ym1);
      end
      C_E2: begin
        ma = b2;
        mb = tmp;
      end
      C_E3: begin
        ma = a2;
        mb = tmp;
      end
      C_E4: begin
        ma = a2;
        mb = MBW'(b2);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    a2   <= MAW'(semi_x) * MAW'(semi_x);
    b2   <= MAW'(semi_y) * MAW'(semi_y);
    prod <= PRW'(ma) * PRW'(mb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= C_IDLE;
      running <= 1'b0;
      in_two  <= 1'b0;
      is_adv  <= 1'b0;
      step_x  <= '0;
      step_y  <= '0;
      cen_x   <= '0;
      cen_y   <= '0;
    end else begin
      case (state)
        C_IDLE: begin
          if (pop_ok) begin
            if (q_kind == ellr_pkg::KIND_START) begin
              cen_x  <= q_cx;
              cen_y  <= q_cy;
              is_adv <= 1'b0;
              state  <= C_ST0;
            end else if (running) begin
              is_adv <= 1'b1;
              state  <= in_two ? C_R2A : C_R1A;
            end
          end
        end
        C_ST0: begin
          step_x <= '0;
          step_y <= semi_y;
          in_two <= 1'b0;
          dx     <= '0;
          state  <= C_ST1;
        end
        C_ST1: begin
          dy      <= prod_x2;
          dec     <= x4(b2e) - x4(DW'(prod)) + a2e;
          running <= 1'b1;
          state   <= C_SET;
        end
        C_R1A: begin
          step_x <= x_inc;
          state  <= C_R1B;
        end
        C_R1B: begin
          dx <= prod_x2;
          if (p_neg) begin
            dec   <= dec + x4(sext(prod_x2) + b2e);
            state <= C_SET;
          end else begin
            step_y <= y_dec;
            state  <= C_R1C;
          end
        end
        C_R1C: begin
          dy    <= prod_x2;
          dec   <= dec + x4(sext(dx) - sext(prod_x2) + b2e);
          state <= C_SET;
        end
        C_R2A: begin
          step_y <= y_dec;
          if (p_pos) begin
            state <= C_R2B;
          end else begin
            step_x <= x_inc;
            dy     <= dy_alt;
            dx     <= dx_alt;
            dec    <= dec + x4(sext(dx_alt) - sext(dy_alt) + a2e);
            state  <= C_SET;
          end
        end
        C_R2B: begin
          dy    <= prod_x2;
          dec   <= dec + x4(a2e - sext(prod_x2));
          state <= C_SET;
        end
        C_SET: begin
          if (set_enter) begin
            state <= C_E0;
          end else begin
            running <= !(in_two && (step_y == '0));
            state   <= C_IDLE;
          end
        end
        C_E0: begin
          state <= C_E1;
        end
        C_E1: begin
          tmp   <= prod[MBW-1:0];   // (2x+1)^2
          state <= C_E2;
        end
        C_E2: begin
          tmp   <= prod[MBW-1:0];   // (y-1)^2
          state <= C_E3;
        end
        C_E3: begin
          acc   <= DW'(prod);
          state <= C_E4;
        end
        C_E4: begin
          acc   <= acc + x4(DW'(prod));
          state <= C_E5;
        end
        C_E5: begin
          dec     <= acc - x4(DW'(prod));
          in_two  <= 1'b1;
          running <= (step_y != '0);
          state   <= C_IDLE;
        end
        default: begin
          state <= C_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/ellr_emit.sv =====
module ellr_emit #(
  parameter int COORD_BITS = 11,
  parameter int AXIS_BITS  = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ellr_pkg::emit_ctl_t          emit_ctl,
  input  logic [AXIS_BITS-1:0]         cur_x,
  input  logic [AXIS_BITS-1:0]         cur_y,
  input  logic [COORD_BITS-1:0]        cen_x,
  input  logic [COORD_BITS-1:0]        cen_y,
  output logic                         emit_busy,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS+1:0] pixel_x,
  output logic signed [COORD_BITS+1:0] pixel_y,
  output logic                         group_last,
  output logic                         curve_end
);

  localparam int PW = COORD_BITS + 2;

  logic                  busy;
  logic [1:0]            k;
  logic                  end_known;
  logic                  end_val;
  logic [AXIS_BITS-1:0]  sx;
  logic [AXIS_BITS-1:0]  sy;
  logic [COORD_BITS-1:0] scx;
  logic [COORD_BITS-1:0] scy;

  logic [PW-1:0] ox_pos;
  logic [PW-1:0] oy_pos;
  logic [PW-1:0] ox;
  logic [PW-1:0] oy;
  logic [PW-1:0] px;
  logic [PW-1:0] py;
  logic          k_last;
  logic          have;
  logic          load;

  assign emit_busy = busy;

  assign ox_pos = PW'(sx);
  assign oy_pos = PW'(sy);
  assign ox     = k[0] ? -ox_pos : ox_pos;
  assign oy     = k[1] ? -oy_pos : oy_pos;
  assign px     = PW'(scx) + ox;
  assign py     = PW'(scy) + oy;
  assign k_last = (k == 2'd3);

  // last pixel of a group waits for the step result to know curve end
  assign have = busy && (!k_last || end_known);
  assign load = have && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (emit_ctl.launch) begin
      sx  <= cur_x;
      sy  <= cur_y;
      scx <= cen_x;
      scy <= cen_y;
    end
    if (emit_ctl.fin) begin
      end_val <= emit_ctl.fin_end;
    end
    if (load) begin
      pixel_x    <= $signed(px);
      pixel_y    <= $signed(py);
      group_last <= k_last;
      curve_end  <= k_last && end_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      k         <= '0;
      end_known <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit_ctl.launch) begin
        busy      <= 1'b1;
        k         <= '0;
        end_known <= 1'b0;
      end else if (load) begin
        k <= k + 1'b1;
        if (k_last) begin
          busy      <= 1'b0;
          end_known <= 1'b0;
        end
      end
      if (emit_ctl.fin) begin
        end_known <= 1'b1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/midpoint_ellipse_raster.sv =====
// Throughput: one pixel per cycle while out_stall is low, but the last pixel of a
// group waits for its step result. An advance runs R1A, R1B (and R1C) or R2A
// (and R2B), then SET, on the step sequencer's shared multiplier; entering region two adds E0-E5.
// A start item runs ST0, ST1 and SET, plus E0-E5 when the curve starts in region two.
// Reset (synchronous, active high) empties the queue, idles the sequencer and
// output, and loads the semi-axes with 70 and 50.
module midpoint_ellipse_raster #(
  parameter int COORD_BITS = 11,
  parameter int AXIS_BITS  = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ellr_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [AXIS_BITS-1:0]                cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                mode,
  input  logic [COORD_BITS-1:0]               center_x,
  input  logic [COORD_BITS-1:0]               center_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [COORD_BITS+1:0]        pixel_x,
  output logic signed [COORD_BITS+1:0]        pixel_y,
  output logic                                group_last,
  output logic                                curve_end
);

  logic [AXIS_BITS-1:0]  semi_x;
  logic [AXIS_BITS-1:0]  semi_y;
  logic                  q_valid;
  logic                  q_kind;
  logic [COORD_BITS-1:0] q_cx;
  logic [COORD_BITS-1:0] q_cy;
  logic                  q_pop;
  logic                  emit_busy;
  ellr_pkg::emit_ctl_t   emit_ctl;
  logic [AXIS_BITS-1:0]  cur_x;
  logic [AXIS_BITS-1:0]  cur_y;
  logic [COORD_BITS-1:0] cen_x;
  logic [COORD_BITS-1:0] cen_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      semi_x <= AXIS_BITS'(ellr_pkg::SEMI_AXIS_X_RST);
      semi_y <= AXIS_BITS'(ellr_pkg::SEMI_AXIS_Y_RST);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ellr_pkg::CFG_SEMI_AXIS_X: semi_x <= cfg_data;
        ellr_pkg::CFG_SEMI_AXIS_Y: semi_y <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ellr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mode     (mode),
    .center_x (center_x),
    .center_y (center_y),
    .q_valid  (q_valid),
    .q_kind   (q_kind),
    .q_cx     (q_cx),
    .q_cy     (q_cy),
    .q_pop    (q_pop)
  );

  ellr_core #(
    .COORD_BITS(COORD_BITS),
    .AXIS_BITS (AXIS_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .semi_x    (semi_x),
    .semi_y    (semi_y),
    .q_valid   (q_valid),
    .q_kind    (q_kind),
    .q_cx      (q_cx),
    .q_cy      (q_cy),
    .q_pop     (q_pop),
    .emit_busy (emit_busy),
    .emit_ctl  (emit_ctl),
    .cur_x     (cur_x),
    .cur_y     (cur_y),
    .cen_x     (cen_x),
    .cen_y     (cen_y)
  );

  ellr_emit #(
    .COORD_BITS(COORD_BITS),
    .AXIS_BITS (AXIS_BITS)
  ) u_emit (
    .clk        (clk),
    .rst        (rst),
    .emit_ctl   (emit_ctl),
    .cur_x      (cur_x),
    .cur_y      (cur_y),
    .cen_x      (cen_x),
    .cen_y      (cen_y),
    .emit_busy  (emit_busy),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .group_last (group_last),
    .curve_end  (curve_end)
  );

endmodule

// ===== hw/rtl/ellr_check.sv =====
module ellr_check #(
  parameter int COORD_BITS = 11
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic signed [COORD_BITS+1:0] pixel_x,
  input logic signed [COORD_BITS+1:0] pixel_y,
  input logic                         group_last,
  input logic                         curve_end
);

  // output register comes out of reset empty
  a_out_idle_after_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set right after reset");

  // queue comes out of reset empty
  a_in_open_after_rst: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("in_stall set right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=>
      out_valid && $stable(pixel_x) && $stable(pixel_y) &&
      $stable(group_last) && $stable(curve_end))
    else $error("stalled output item changed");

  // the curve only ends on the closing pixel of a group
  a_end_on_group: assert property (@(posedge clk) disable iff (rst)
    out_valid && curve_end |-> group_last)
    else $error("curve_end without group_last");

endmodule

bind midpoint_ellipse_raster ellr_check #(
  .COORD_BITS(COORD_BITS)
) u_ellr_check (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .pixel_x    (pixel_x),
  .pixel_y    (pixel_y),
  .group_last (group_last),
  .curve_end  (curve_end)
);

// ===== bench/ellipse_pixel_checker.sv =====
`timescale 1ns / 1ps
module ellipse_pixel_checker #(
  parameter int COORD_BITS = 11,
  parameter int AXIS_BITS  = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [ellr_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [AXIS_BITS-1:0]                cfg_data,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                mode,
  input  logic [COORD_BITS-1:0]               center_x,
  input  logic [COORD_BITS-1:0]               center_y,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [COORD_BITS+1:0]        pixel_x,
  input  logic signed [COORD_BITS+1:0]        pixel_y,
  input  logic                                group_last,
  input  logic                                curve_end,
  input  logic                                end_check,
  output int                                  mismatches,
  output int                                  pending
);

  localparam int PIX_W   = COORD_BITS + 2;
  localparam int SLOPE_W = 3 * AXIS_BITS + 4;
  localparam int DEC_W   = 4 * AXIS_BITS + 8;

  typedef struct packed {
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] py;
    logic             last;
    logic             fin;
  } pixel_t;

  pixel_t pixel_q[$];

  // live semi-axes and the rasterizer state
  logic [AXIS_BITS-1:0]     axis_a, axis_b;
  logic [COORD_BITS-1:0]    ctr_col, ctr_row;
  logic [AXIS_BITS-1:0]     cur_x, cur_y;
  logic                     region2, drawing;
  logic signed [DEC_W-1:0]  dec4;
  logic signed [SLOPE_W-1:0] dxs, dys;
  bit                       end_done;

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  // test the loop conditions: switch to region two, or stop at y == 0
  task automatic settle_region();
    longint a2, b2, t, ym1, tmp;
    a2 = longint'(axis_a) * longint'(axis_a);
    b2 = longint'(axis_b) * longint'(axis_b);
    if (!region2 && !(dxs < dys)) begin
      t = 2 * longint'(cur_x) + 1;
      ym1 = longint'(cur_y) - 1;
      region2 = 1'b1;
      tmp = b2 * t * t + 4 * a2 * ym1 * ym1 - 4 * a2 * b2;
      dec4 = tmp[DEC_W-1:0];
    end
    if (region2 && cur_y == '0)
      drawing = 1'b0;
  endtask

  task automatic dec_row();
    if (cur_y != '0)
      cur_y = cur_y - 1'b1;
  endtask

  task automatic advance_point();
    longint a2, b2, p, tmp;
    a2 = longint'(axis_a) * longint'(axis_a);
    b2 = longint'(axis_b) * longint'(axis_b);
    p = longint'(dec4);
    if (!region2) begin
      cur_x = cur_x + 1'b1;
      tmp = 2 * b2 * longint'(cur_x);
      dxs = tmp[SLOPE_W-1:0];
      if (p < 0) begin
        p += 4 * (longint'(dxs) + b2);
      end else begin
        dec_row();
        tmp = 2 * a2 * longint'(cur_y);
        dys = tmp[SLOPE_W-1:0];
        p += 4 * (longint'(dxs) - longint'(dys) + b2);
      end
    end else if (p > 0) begin
      dec_row();
      tmp = 2 * a2 * longint'(cur_y);
      dys = tmp[SLOPE_W-1:0];
      p += 4 * (a2 - longint'(dys));
    end else begin
      cur_x = cur_x + 1'b1;
      dec_row();
      tmp = longint'(dys) - 2 * a2;
      dys = tmp[SLOPE_W-1:0];
      tmp = longint'(dxs) + 2 * b2;
      dxs = tmp[SLOPE_W-1:0];
      p += 4 * (longint'(dxs) - longint'(dys) + a2);
    end
    dec4 = p[DEC_W-1:0];
  endtask

  task automatic trace_item(input logic m, input logic [COORD_BITS-1:0] cx,
                            input logic [COORD_BITS-1:0] cy);
    pixel_t grp[4];
    longint a2, b2, tmp;
    a2 = longint'(axis_a) * longint'(axis_a);
    b2 = longint'(axis_b) * longint'(axis_b);
    if (m == ellr_pkg::KIND_START) begin
      ctr_col = cx;
      ctr_row = cy;
      cur_x = '0;
      cur_y = axis_b;
      region2 = 1'b0;
      drawing = 1'b1;
      dxs = '0;
      tmp = 2 * a2 * longint'(axis_b);
      dys = tmp[SLOPE_W-1:0];
      tmp = 4 * b2 - 4 * a2 * longint'(axis_b) + a2;
      dec4 = tmp[DEC_W-1:0];
      settle_region();
    end else if (drawing) begin
      // mirror order: (+x,+y) (-x,+y) (+x,-y) (-x,-y)
      for (int k = 0; k < 4; k++) begin
        tmp = longint'(ctr_col) + ((k & 1) ? -longint'(cur_x) : longint'(cur_x));
        grp[k].px = tmp[PIX_W-1:0];
        tmp = longint'(ctr_row) + ((k & 2) ? -longint'(cur_y) : longint'(cur_y));
        grp[k].py = tmp[PIX_W-1:0];
        grp[k].last = (k == 3);
        grp[k].fin = 1'b0;
      end
      advance_point();
      settle_region();
      if (!drawing)
        grp[3].fin = 1'b1;
      for (int k = 0; k < 4; k++)
        pixel_q.push_back(grp[k]);
    end
  endtask

  task automatic check_pixel();
    pixel_t e;
    if (pixel_q.size() == 0) begin
      report_mismatch($sformatf("pixel (%0d,%0d) with none expected", pixel_x, pixel_y));
    end else begin
      e = pixel_q.pop_front();
      if (pixel_x !== e.px)
        report_mismatch($sformatf("pixel_x %0d, want %0d", pixel_x, $signed(e.px)));
      if (pixel_y !== e.py)
        report_mismatch($sformatf("pixel_y %0d, want %0d", pixel_y, $signed(e.py)));
      if (group_last !== e.last)
        report_mismatch($sformatf("group_last %b, want %b", group_last, e.last));
      if (curve_end !== e.fin)
        report_mismatch($sformatf("curve_end %b, want %b", curve_end, e.fin));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      axis_a = AXIS_BITS'(ellr_pkg::SEMI_AXIS_X_RST);
      axis_b = AXIS_BITS'(ellr_pkg::SEMI_AXIS_Y_RST);
      ctr_col = '0;
      ctr_row = '0;
      cur_x = '0;
      cur_y = '0;
      region2 = 1'b0;
      drawing = 1'b0;
      dec4 = '0;
      dxs = '0;
      dys = '0;
      pixel_q.delete();
      mismatches = 0;
      end_done = 1'b0;
    end else begin
      if (out_valid && !out_stall)
        check_pixel();
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ellr_pkg::CFG_SEMI_AXIS_X)
          axis_a = cfg_data;
        else
          axis_b = cfg_data;
      end
      if (in_valid && !in_stall)
        trace_item(mode, center_x, center_y);
      if (end_check && !end_done) begin
        end_done = 1'b1;
        if (pixel_q.size() != 0)
          report_mismatch($sformatf("%0d pixels never arrived", pixel_q.size()));
      end
    end
    pending <= pixel_q.size();
  end

endmodule

// ===== bench/tb_midpoint_ellipse_raster.sv =====
`timescale 1ns / 1ps
module tb_midpoint_ellipse_raster;

  localparam int COORD_BITS    = 11;
  localparam int AXIS_BITS     = 10;
  localparam int ITEM_TARGET   = 310;
  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int AXIS_MAX      = (1 << AXIS_BITS) - 1;
  localparam int COORD_MAX     = (1 << COORD_BITS) - 1;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [ellr_pkg::CFG_IDX_BITS-1:0]   cfg_index = ellr_pkg::CFG_SEMI_AXIS_X;
  logic [AXIS_BITS-1:0]                cfg_data = '0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic                                mode = ellr_pkg::KIND_START;
  logic [COORD_BITS-1:0]               center_x = '0;
  logic [COORD_BITS-1:0]               center_y = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic signed [COORD_BITS+1:0]        pixel_x, pixel_y;
  logic                                group_last, curve_end;
  logic                                end_check = 1'b0;
  logic                                hold_req = 1'b0;
  int                                  mismatches, pending;
  int                                  items_sent = 0;
  int                                  burst_left = 0;
  int                                  quiet = 0;
  bit                                  fast = 1'b0;
  int                                  axis_a = ellr_pkg::SEMI_AXIS_X_RST;
  int                                  axis_b = ellr_pkg::SEMI_AXIS_Y_RST;

  midpoint_ellipse_raster #(
    .COORD_BITS(COORD_BITS),
    .AXIS_BITS (AXIS_BITS)
  ) dut (.*);

  ellipse_pixel_checker #(
    .COORD_BITS(COORD_BITS),
    .AXIS_BITS (AXIS_BITS)
  ) checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [COORD_BITS-1:0] rand_coord();
    return COORD_BITS'($urandom_range(0, COORD_MAX));
  endfunction

  function automatic logic rand_kind();
    return ($urandom_range(0, 1) == 0) ? ellr_pkg::KIND_START : ellr_pkg::KIND_ADV;
  endfunction

  // mostly small axes so curves run to the end; zero and full scale now and then
  function automatic int pick_axis();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0)
      return 0;
    else if (r == 1)
      return AXIS_MAX;
    else if (r < 4)
      return $urandom_range(0, AXIS_MAX);
    return $urandom_range(1, 12);
  endfunction

  task automatic send(input logic m, input logic [COORD_BITS-1:0] cx,
                      input logic [COORD_BITS-1:0] cy);
    int gap;
    mode <= m;
    center_x <= cx;
    center_y <= cy;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 10);
      gap = fast ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic write_axis(input logic [ellr_pkg::CFG_IDX_BITS-1:0] idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= AXIS_BITS'(val);
    do @(posedge clk); while (!cfg_ready);
    if (idx == ellr_pkg::CFG_SEMI_AXIS_X)
      axis_a = val;
    else
      axis_b = val;
  endtask

  // order: 0 x then y, 1 y then x, 2 x only, 3 y only
  task automatic configure(input int a, input int b, input int order);
    case (order)
      0: begin
        write_axis(ellr_pkg::CFG_SEMI_AXIS_X, a);
        write_axis(ellr_pkg::CFG_SEMI_AXIS_Y, b);
      end
      1: begin
        write_axis(ellr_pkg::CFG_SEMI_AXIS_Y, b);
        write_axis(ellr_pkg::CFG_SEMI_AXIS_X, a);
      end
      2: write_axis(ellr_pkg::CFG_SEMI_AXIS_X, a);
      default: write_axis(ellr_pkg::CFG_SEMI_AXIS_Y, b);
    endcase
    cfg_valid <= 1'b0;
  endtask

  // wait out every expected pixel, then give idle advances time to retire
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic draw_curve(input int steps);
    send(ellr_pkg::KIND_START, rand_coord(), rand_coord());
    for (int i = 0; i < steps; i++) begin
      if ($urandom_range(0, 19) == 0)
        send(ellr_pkg::KIND_START, rand_coord(), rand_coord());
      send(ellr_pkg::KIND_ADV, rand_coord(), rand_coord());
    end
  endtask

  initial begin : stim
    int steps;
    int n;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // nothing drawn yet; reset axes with the center at the origin (wraps below zero)
    send(ellr_pkg::KIND_ADV, '1, '1);
    send(ellr_pkg::KIND_START, '0, '0);
    repeat (4) send(ellr_pkg::KIND_ADV, '0, '0);
    drain();

    // tiny ellipse at the far corner, run past its end
    configure(3, 2, 0);
    send(ellr_pkg::KIND_START, '1, '1);
    repeat (7) send(ellr_pkg::KIND_ADV, '0, '1);
    drain();

    // a = 0: region one skipped, vertical line
    configure(0, 3, 0);
    send(ellr_pkg::KIND_START, COORD_BITS'(1024), COORD_BITS'(5));
    repeat (5) send(ellr_pkg::KIND_ADV, '1, '0);
    drain();

    // b = 0: empty ellipse
    configure(0, 0, 3);
    send(ellr_pkg::KIND_START, COORD_BITS'(7), COORD_BITS'(9));
    send(ellr_pkg::KIND_ADV, '0, '0);
    drain();

    configure(AXIS_MAX, AXIS_MAX, 1);
    send(ellr_pkg::KIND_START, '1, '0);
    repeat (2) send(ellr_pkg::KIND_ADV, '0, '0);
    drain();

    // long curve while the sink holds off, so the block backs up
    configure(40, 30, 0);
    fast = 1'b1;
    hold_req <= 1'b1;
    draw_curve(75);
    drain();

    while (items_sent < ITEM_TARGET) begin
      fast = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) != 0)
        configure(pick_axis(), pick_axis(), $urandom_range(0, 3));
      if ($urandom_range(0, 6) == 0) begin
        n = $urandom_range(1, 8);
        repeat (n) send(rand_kind(), rand_coord(), rand_coord());
      end else if ($urandom_range(0, 5) == 0) begin
        // keep stepping whatever curve is live, under the new axes
        n = $urandom_range(1, 8);
        repeat (n) send(ellr_pkg::KIND_ADV, rand_coord(), rand_coord());
      end else begin
        steps = $urandom_range(1, axis_a + axis_b + 3);
        if (steps > 48)
          steps = 48;
        draw_curve(steps);
      end
      drain();
    end

    end_check <= 1'b1;
    @(posedge clk);
    @(posedge clk);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin : sink
    int seg;
    int kind;
    bit held;
    held = 1'b0;
    forever begin
      kind = $urandom_range(0, 2);
      seg = $urandom_range(8, 60);
      repeat (seg) begin
        @(posedge clk);
        if (hold_req && !held) begin
          held = 1'b1;
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (kind)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 9) < 6);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

endmodule

// ===== filelist.f =====
hw/rtl/ellr_pkg.sv
hw/rtl/ellr_front.sv
hw/rtl/ellr_core.sv
hw/rtl/ellr_emit.sv
hw/rtl/midpoint_ellipse_raster.sv
hw/rtl/ellr_check.sv
bench/ellipse_pixel_checker.sv
bench/tb_midpoint_ellipse_raster.sv
